// ===== rtl/core/bb3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared constants, codes and stage types of the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

	localparam int WIDTH  = 1024;
	localparam int HEIGHT = 768;
	localparam int TOTAL  = WIDTH * HEIGHT;

	// slot counter covers a whole frame plus its drain tail
	localparam int PW = $clog2(TOTAL + WIDTH + 2);
	localparam int XW = $clog2(WIDTH);
	localparam int YW = $clog2(HEIGHT);

	// nine 8-bit samples sum to at most 2295
	localparam int SW = 12;

	// x / 9 == (x * 7282) >> 16 for every x below 4096
	localparam int            RW     = 14;
	localparam logic [RW-1:0] RECIP9 = 14'd7282;
	localparam int            RSH    = 16;
	localparam int            PRW    = SW + RW;

	localparam logic [7:0] ALPHA = 8'hFF;

	// result queue
	localparam int FD  = 8;
	localparam int FAW = $clog2(FD);
	localparam int FCW = $clog2(FD + 1);

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	typedef logic [23:0] rgb_t;

	typedef struct packed {
		logic          en;
		logic [XW-1:0] addr;
	} rd_req_t;

	typedef struct packed {
		logic          push;
		logic          emit;
		rgb_t          rgb;
		logic [XW-1:0] col;
		logic [XW-1:0] x;
		logic [YW-1:0] y;
		logic          last;
	} slot_t;

	typedef struct packed {
		logic          emit;
		logic [SW-1:0] rs;
		logic [SW-1:0] gs;
		logic [SW-1:0] bs;
		logic [XW-1:0] x;
		logic [YW-1:0] y;
		logic          last;
	} sum_t;

	typedef struct packed {
		logic        frame_end;
		logic [9:0]  row;
		logic [9:0]  col;
		logic [31:0] color;
	} res_t;

endpackage

// ===== rtl/core/bb3_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_ctrl
// Slot and output position counters; decodes each beat into a line store
// read and a stage-1 slot.
// ----------------------------------------------------------------------------
module bb3_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  bb3_pkg::op_t     opcode,
	input  logic [31:0]      pixel,
	output bb3_pkg::rd_req_t req,
	output bb3_pkg::slot_t   slot_s1
);

	logic [bb3_pkg::PW-1:0] in_pos_q;
	logic [bb3_pkg::XW-1:0] in_col_q;
	logic [bb3_pkg::XW-1:0] out_x_q;
	logic [bb3_pkg::YW-1:0] out_y_q;

	logic tail;
	logic push;
	logic emit;
	logic last;

	assign tail = in_pos_q >= bb3_pkg::PW'(bb3_pkg::TOTAL);
	assign push = accept && (tail || opcode == bb3_pkg::OP_PIXEL);
	assign emit = push && (tail || in_pos_q >= bb3_pkg::PW'(bb3_pkg::WIDTH + 1));
	assign last = (out_x_q == bb3_pkg::XW'(bb3_pkg::WIDTH - 1)) &&
	              (out_y_q == bb3_pkg::YW'(bb3_pkg::HEIGHT - 1));

	assign req.en   = push;
	assign req.addr = in_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pos_q <= '0;
			in_col_q <= '0;
			out_x_q  <= '0;
			out_y_q  <= '0;
		end else if (push) begin
			if (emit && last) begin
				// frame done: restart all positions
				in_pos_q <= '0;
				in_col_q <= '0;
				out_x_q  <= '0;
				out_y_q  <= '0;
			end else begin
				in_pos_q <= in_pos_q + 1'b1;
				in_col_q <= (in_col_q == bb3_pkg::XW'(bb3_pkg::WIDTH - 1)) ?
				            '0 : in_col_q + 1'b1;
				if (emit) begin
					if (out_x_q == bb3_pkg::XW'(bb3_pkg::WIDTH - 1)) begin
						out_x_q <= '0;
						out_y_q <= out_y_q + 1'b1;
					end else begin
						out_x_q <= out_x_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_s1 <= '0;
		end else begin
			slot_s1.push <= push;
			slot_s1.emit <= emit;
			if (push) begin
				// tail beats shift in black
				slot_s1.rgb  <= tail ? '0 : pixel[31:8];
				slot_s1.col  <= in_col_q;
				slot_s1.x    <= out_x_q;
				slot_s1.y    <= out_y_q;
				slot_s1.last <= last;
			end
		end
	end

	property p_pos_bound;
		@(posedge clk) disable iff (!arst_n)
		in_pos_q <= bb3_pkg::PW'(bb3_pkg::TOTAL + bb3_pkg::WIDTH + 1);
	endproperty
	a_pos_bound: assert property (p_pos_bound)
		else $error("slot counter ran past the drain tail");

endmodule

// ===== rtl/core/bb3_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_window
// Two line stores in one dual-lane RAM, the 3x3 window and the masked
// neighbourhood sums.
// ----------------------------------------------------------------------------
module bb3_window (
	input  logic             clk,
	input  logic             arst_n,
	input  bb3_pkg::rd_req_t req,
	input  bb3_pkg::slot_t   slot_s1,
	output logic             emit_s2,
	output bb3_pkg::sum_t    sum_s3
);

	// upper line in 47:24, lower line in 23:0
	logic [47:0]         mem [bb3_pkg::WIDTH];
	logic [47:0]         rdata_q;
	bb3_pkg::rgb_t       win_q [9];

	logic [bb3_pkg::XW-1:0] x_s2;
	logic [bb3_pkg::YW-1:0] y_s2;
	logic                   last_s2;

	logic [2:0]             row_ok;
	logic [2:0]             col_ok;
	logic [bb3_pkg::SW-1:0] rs;
	logic [bb3_pkg::SW-1:0] gs;
	logic [bb3_pkg::SW-1:0] bs;

	// read at stage 0, write back the rotated column at stage 1;
	// forward the write when both hit the same entry at frame restart
	always_ff @(posedge clk) begin
		if (req.en)
			rdata_q <= (slot_s1.push && slot_s1.col == req.addr) ?
			           {rdata_q[23:0], slot_s1.rgb} : mem[req.addr];
		if (slot_s1.push)
			mem[slot_s1.col] <= {rdata_q[23:0], slot_s1.rgb};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				win_q[i] <= '0;
		end else if (slot_s1.push) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3+0] <= win_q[k*3+1];
				win_q[k*3+1] <= win_q[k*3+2];
			end
			win_q[2] <= rdata_q[47:24];
			win_q[5] <= rdata_q[23:0];
			win_q[8] <= slot_s1.rgb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			emit_s2 <= 1'b0;
		else
			emit_s2 <= slot_s1.emit;
	end

	always_ff @(posedge clk) begin
		if (slot_s1.emit) begin
			x_s2    <= slot_s1.x;
			y_s2    <= slot_s1.y;
			last_s2 <= slot_s1.last;
		end
	end

	// drop neighbours outside the frame
	always_comb begin
		row_ok[0] = y_s2 != '0;
		row_ok[1] = 1'b1;
		row_ok[2] = y_s2 != bb3_pkg::YW'(bb3_pkg::HEIGHT - 1);
		col_ok[0] = x_s2 != '0;
		col_ok[1] = 1'b1;
		col_ok[2] = x_s2 != bb3_pkg::XW'(bb3_pkg::WIDTH - 1);
		rs = '0;
		gs = '0;
		bs = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (row_ok[r] && col_ok[c]) begin
					rs = rs + bb3_pkg::SW'(win_q[r*3+c][23:16]);
					gs = gs + bb3_pkg::SW'(win_q[r*3+c][15:8]);
					bs = bs + bb3_pkg::SW'(win_q[r*3+c][7:0]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_s3 <= '0;
		end else begin
			sum_s3.emit <= emit_s2;
			if (emit_s2) begin
				sum_s3.rs   <= rs;
				sum_s3.gs   <= gs;
				sum_s3.bs   <= bs;
				sum_s3.x    <= x_s2;
				sum_s3.y    <= y_s2;
				sum_s3.last <= last_s2;
			end
		end
	end

	property p_stage_order;
		@(posedge clk) disable iff (!arst_n)
		slot_s1.emit |=> ##1 sum_s3.emit;
	endproperty
	a_stage_order: assert property (p_stage_order)
		else $error("sum stage lost an output slot");

endmodule

// ===== rtl/core/bb3_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_scale
// Divides the three channel sums by nine and packs the result beat.
// ----------------------------------------------------------------------------
module bb3_scale (
	input  bb3_pkg::sum_t sum_s3,
	output bb3_pkg::res_t res
);

	function automatic logic [7:0] div9(input logic [bb3_pkg::SW-1:0] s);
		logic [bb3_pkg::PRW-1:0] p;
		p = bb3_pkg::PRW'(s) * bb3_pkg::PRW'(bb3_pkg::RECIP9);
		return p[bb3_pkg::RSH +: 8];
	endfunction

	assign res.color     = {div9(sum_s3.rs), div9(sum_s3.gs), div9(sum_s3.bs), bb3_pkg::ALPHA};
	assign res.col       = 10'(sum_s3.x);
	assign res.row       = 10'(sum_s3.y);
	assign res.frame_end = sum_s3.last;

endmodule

// ===== rtl/core/bb3_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_out_fifo
// Register queue that decouples the blur pipeline from the result channel.
// ----------------------------------------------------------------------------
module bb3_out_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  bb3_pkg::res_t           wr_data,
	input  logic                    rd_en,
	output logic                    rd_valid,
	output bb3_pkg::res_t           rd_data,
	output logic [bb3_pkg::FCW-1:0] count
);

	bb3_pkg::res_t           buf_q [bb3_pkg::FD];
	logic [bb3_pkg::FAW-1:0] wp_q;
	logic [bb3_pkg::FAW-1:0] rp_q;
	logic [bb3_pkg::FCW-1:0] cnt_q;
	logic                    pop;

	assign rd_valid = cnt_q != '0;
	assign rd_data  = buf_q[rp_q];
	assign count    = cnt_q;
	assign pop      = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (wr_en)
			buf_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			case ({wr_en, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n)
		(cnt_q == bb3_pkg::FCW'(bb3_pkg::FD)) |-> (!wr_en || pop);
	endproperty
	a_no_overflow: assert property (p_no_overflow)
		else $error("result queue overflow");

endmodule

// ===== rtl/core/box_blur_3x3_rgb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// 3x3 box blur over an RGBA raster stream with two line stores.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while s_tready is high; the line store RAM is read
//   once and written once per beat, a write forwarded into a read of the same entry.
// A result leaves after the beat that completes its neighbourhood by way of the
//   RAM read, window shift, sums and the divide into the queue.
// s_tready drops only when the 8-entry result queue plus beats in flight fill.
// Reset clears counters, window and queue at once; line stores are not cleared.
module box_blur_3x3_rgb (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // pixel[31:0]
	input  logic [0:0]  s_tuser,   // opcode[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // color[31:0], col[41:32], row[51:42], zero[55:52]
	output logic        m_tlast    // frame_end
);

	bb3_pkg::rd_req_t        req;
	bb3_pkg::slot_t          slot_s1;
	logic                    emit_s2;
	bb3_pkg::sum_t           sum_s3;
	bb3_pkg::res_t           res;
	bb3_pkg::res_t           head;
	logic [bb3_pkg::FCW-1:0] count;
	logic [bb3_pkg::FCW-1:0] occupancy;
	logic                    accept;

	assign occupancy = count + bb3_pkg::FCW'(slot_s1.emit) + bb3_pkg::FCW'(emit_s2) +
	                   bb3_pkg::FCW'(sum_s3.emit);
	assign s_tready  = occupancy < bb3_pkg::FCW'(bb3_pkg::FD);
	assign accept    = s_tvalid && s_tready;

	bb3_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.opcode  (bb3_pkg::op_t'(s_tuser[0])),
		.pixel   (s_tdata),
		.req     (req),
		.slot_s1 (slot_s1)
	);

	bb3_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.slot_s1 (slot_s1),
		.emit_s2 (emit_s2),
		.sum_s3  (sum_s3)
	);

	bb3_scale u_scale (
		.sum_s3 (sum_s3),
		.res    (res)
	);

	bb3_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (sum_s3.emit),
		.wr_data  (res),
		.rd_en    (m_tready),
		.rd_valid (m_tvalid),
		.rd_data  (head),
		.count    (count)
	);

	assign m_tdata = {4'b0000, head.row, head.col, head.color};
	assign m_tlast = head.frame_end;

	property p_occupancy;
		@(posedge clk) disable iff (!arst_n)
		occupancy <= bb3_pkg::FCW'(bb3_pkg::FD);
	endproperty
	a_occupancy: assert property (p_occupancy)
		else $error("more results in flight than queue entries");

	property p_last_corner;
		@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |->
			(m_tdata[41:32] == 10'(bb3_pkg::WIDTH - 1) &&
			 m_tdata[51:42] == 10'(bb3_pkg::HEIGHT - 1));
	endproperty
	a_last_corner: assert property (p_last_corner)
		else $error("frame end flagged away from the last pixel");

	property p_alpha;
		@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:0] == bb3_pkg::ALPHA);
	endproperty
	a_alpha: assert property (p_alpha)
		else $error("result beat without opaque alpha");

endmodule
